FILE: sv/rbs_pkg.sv
// Shared types, register codes and box-bound helpers for the ray/box slab tester.
package rbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_BITS      = 33;
    localparam int OFS_BITS      = 35;
    localparam int T_BITS        = QUO_BITS + 1;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SIZE_X   = 3'd3,
        REG_SIZE_Y   = 3'd4,
        REG_SIZE_Z   = 3'd5,
        REG_FACE_TOL = 3'd6
    } rbs_reg_t;

    typedef struct packed {
        logic signed [31:0] t_upper;
        logic signed [31:0] t_lower;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
        logic signed [31:0] origin_z;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_x;
    } rbs_ray_t;

    typedef struct packed {
        logic              front_face;
        logic signed [1:0] normal_z;
        logic signed [1:0] normal_y;
        logic signed [1:0] normal_x;
        logic signed [31:0] point_z;
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
        logic signed [31:0] t_hit;
        logic              hit;
    } rbs_out_t;

    typedef struct packed {
        logic signed [T_BITS-1:0] t_near;
        logic signed [T_BITS-1:0] t_far;
        logic signed [31:0]       org;
        logic signed [31:0]       dir;
        logic                     par_miss;
        logic                     dir_zero;
    } rbs_lane_t;

    function automatic logic signed [32:0] box_lo(input logic signed [31:0] c,
                                                  input logic [30:0] s);
        box_lo = {c[31], c} - {3'b000, s[30:1]};
    endfunction

    function automatic logic signed [33:0] box_hi(input logic signed [31:0] c,
                                                  input logic [30:0] s);
        logic signed [32:0] lo;
        lo = box_lo(c, s);
        box_hi = {lo[32], lo} + {3'b000, s};
    endfunction

endpackage

FILE: sv/ray_box_slab_intersect.sv
// Top level: ray against configured axis-aligned box, slab method, one ray per cycle while s_tready is high.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  ray: origin, direction, t interval (256 bits)
//  m_*       out  m_tvalid/m_tready  hit, t_hit, point, normal, front_face (136 bits)
//  cfg_*     in   cfg_we             cfg_addr selects register, cfg_wdata value
//
// One ray per cycle sustained while s_tready is high. A ray passes through 34 stages
// of the bit-per-stage slab dividers, two merge/multiply stages, then the output register.
// Reset clears valid state and loads register defaults; no clearing pass.
// A stalled result waits in the output register; one more lands in a skid register,
// and only then does s_tready drop and the whole pipeline hold.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                                    // t_lower, t_upper
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // hit, t_hit, point_x, point_y, point_z, normal_x,
                                    // normal_y, normal_z, front_face
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import rbs_pkg::*;

    localparam int DEPTH = QUO_BITS + 1;

    rbs_ray_t           ray;
    logic               en;
    logic signed [31:0] ctr_reg  [3];
    logic [30:0]        size_reg [3];
    logic [15:0]        tol_reg;
    rbs_lane_t          lane [3];
    logic signed [31:0] org_in [3];
    logic signed [31:0] dir_in [3];

    logic               vd_reg  [0:DEPTH-1];
    logic signed [31:0] tlo_reg [0:DEPTH-1];
    logic signed [31:0] thi_reg [0:DEPTH-1];

    logic     mrg_valid;
    rbs_out_t mrg_data;
    logic     out_valid_reg, skid_valid_reg;
    rbs_out_t out_reg, skid_reg;

    assign ray      = rbs_ray_t'(s_tdata);
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ctr_reg[i]  <= 32'sd0;
                size_reg[i] <= 31'd65536;
            end
            tol_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (rbs_reg_t'(cfg_addr))
                REG_CENTER_X: ctr_reg[0]  <= cfg_wdata;
                REG_CENTER_Y: ctr_reg[1]  <= cfg_wdata;
                REG_CENTER_Z: ctr_reg[2]  <= cfg_wdata;
                REG_SIZE_X:   size_reg[0] <= cfg_wdata[30:0];
                REG_SIZE_Y:   size_reg[1] <= cfg_wdata[30:0];
                REG_SIZE_Z:   size_reg[2] <= cfg_wdata[30:0];
                REG_FACE_TOL: tol_reg     <= cfg_wdata[15:0];
                default:      tol_reg     <= tol_reg;
            endcase
        end
    end

    assign org_in[0] = ray.origin_x;
    assign org_in[1] = ray.origin_y;
    assign org_in[2] = ray.origin_z;
    assign dir_in[0] = ray.dir_x;
    assign dir_in[1] = ray.dir_y;
    assign dir_in[2] = ray.dir_z;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk  (clk),
            .en   (en),
            .org  (org_in[i]),
            .dir  (dir_in[i]),
            .ctr  (ctr_reg[i]),
            .size (size_reg[i]),
            .res  (lane[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vd_reg[0] <= s_tvalid;
            for (int k = 1; k < DEPTH; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tlo_reg[0] <= ray.t_lower;
            thi_reg[0] <= ray.t_upper;
            for (int k = 1; k < DEPTH; k++)
            begin
                tlo_reg[k] <= tlo_reg[k-1];
                thi_reg[k] <= thi_reg[k-1];
            end
        end
    end

    rbs_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vd_reg[DEPTH-1]),
        .lane      (lane),
        .t_lo      (tlo_reg[DEPTH-1]),
        .t_hi      (thi_reg[DEPTH-1]),
        .ctr       (ctr_reg),
        .size      (size_reg),
        .tol       (tol_reg),
        .out_valid (mrg_valid),
        .out_data  (mrg_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= mrg_valid;
        end
        else if (en && mrg_valid)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= mrg_data;
        end
        else if (en && mrg_valid)
            skid_reg <= mrg_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: sv/rbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating magnitude.
module rbs_div #(
    parameter int NUM_W = 51,
    parameter int QB    = 33
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num_mag,
    input  logic [31:0]          den_mag,
    input  logic                 neg,
    output logic signed [QB:0]   quo
);
    logic [31:0]    rem_reg [0:QB];
    logic [QB-1:0]  low_reg [0:QB];
    logic [31:0]    den_reg [0:QB];
    logic [QB-1:0]  quo_reg [0:QB];
    logic           neg_reg [0:QB];
    logic           ovf_reg [0:QB];
    logic [QB-1:0]  mag;
    logic [QB:0]    mag_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 32'(num_mag[NUM_W-1:QB]);
            ovf_reg[0] <= 32'(num_mag[NUM_W-1:QB]) >= den_mag;
            low_reg[0] <= num_mag[QB-1:0];
            den_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [32:0] trial;
        logic        take;
        assign trial = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign take  = trial >= {1'b0, den_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? 32'(trial - {1'b0, den_reg[k-1]}) : trial[31:0];
                low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QB-2:0], take};
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign mag     = ovf_reg[QB] ? '1 : quo_reg[QB];
    assign mag_ext = {1'b0, mag};
    assign quo     = neg_reg[QB] ? -$signed(mag_ext) : $signed(mag_ext);

endmodule

FILE: sv/rbs_lane.sv
// One axis: slab offsets, two slab-distance dividers and the matching ray delay.
module rbs_lane #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  org,
    input  logic signed [31:0]  dir,
    input  logic signed [31:0]  ctr,
    input  logic [30:0]         size,
    output rbs_pkg::rbs_lane_t  res
);
    import rbs_pkg::*;

    localparam int NUM_W = OFS_BITS + FRAC_BITS;
    localparam int DEPTH = QUO_BITS + 1;

    logic signed [32:0]         lo;
    logic signed [33:0]         hi;
    logic signed [OFS_BITS-1:0] off_a, off_b;
    logic [OFS_BITS-1:0]        mag_a, mag_b;
    logic [31:0]                den;
    logic                       dz, par;
    logic signed [T_BITS-1:0]   qa, qb;

    logic signed [31:0] org_reg [0:DEPTH-1];
    logic signed [31:0] dir_reg [0:DEPTH-1];
    logic               par_reg [0:DEPTH-1];
    logic               dz_reg  [0:DEPTH-1];

    assign lo    = box_lo(ctr, size);
    assign hi    = box_hi(ctr, size);
    assign off_a = {{2{lo[32]}}, lo} - {{3{org[31]}}, org};
    assign off_b = {hi[33], hi} - {{3{org[31]}}, org};
    assign mag_a = off_a[OFS_BITS-1] ? OFS_BITS'(-off_a) : off_a;
    assign mag_b = off_b[OFS_BITS-1] ? OFS_BITS'(-off_b) : off_b;
    assign den   = dir[31] ? (~dir + 32'd1) : dir;
    assign dz    = dir == 32'sd0;
    assign par   = dz && (($signed({org[31], org}) < lo) || ($signed({{2{org[31]}}, org}) > hi));

    rbs_div #(.NUM_W(NUM_W), .QB(QUO_BITS)) u_div_a (
        .clk     (clk),
        .en      (en),
        .num_mag ({mag_a, {FRAC_BITS{1'b0}}}),
        .den_mag (den),
        .neg     (off_a[OFS_BITS-1] ^ dir[31]),
        .quo     (qa)
    );

    rbs_div #(.NUM_W(NUM_W), .QB(QUO_BITS)) u_div_b (
        .clk     (clk),
        .en      (en),
        .num_mag ({mag_b, {FRAC_BITS{1'b0}}}),
        .den_mag (den),
        .neg     (off_b[OFS_BITS-1] ^ dir[31]),
        .quo     (qb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            org_reg[0] <= org;
            dir_reg[0] <= dir;
            par_reg[0] <= par;
            dz_reg[0]  <= dz;
            for (int k = 1; k < DEPTH; k++)
            begin
                org_reg[k] <= org_reg[k-1];
                dir_reg[k] <= dir_reg[k-1];
                par_reg[k] <= par_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
            end
        end
    end

    always_comb
    begin
        res.t_near   = dir_reg[DEPTH-1][31] ? qb : qa;
        res.t_far    = dir_reg[DEPTH-1][31] ? qa : qb;
        res.org      = org_reg[DEPTH-1];
        res.dir      = dir_reg[DEPTH-1];
        res.par_miss = par_reg[DEPTH-1];
        res.dir_zero = dz_reg[DEPTH-1];
    end

endmodule

FILE: sv/rbs_merge.sv
// Combines the three slabs, then hit point, face normal and facing.
module rbs_merge #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rbs_pkg::rbs_lane_t  lane [3],
    input  logic signed [31:0]  t_lo,
    input  logic signed [31:0]  t_hi,
    input  logic signed [31:0]  ctr [3],
    input  logic [30:0]         size [3],
    input  logic [15:0]         tol,
    output logic                out_valid,
    output rbs_pkg::rbs_out_t   out_data
);
    import rbs_pkg::*;

    logic signed [T_BITS-1:0] tmin, tmax;
    logic                     miss;

    logic               v1_reg, v2_reg;
    logic               hit1_reg, hit2_reg;
    logic signed [31:0] tmin1_reg, tmin2_reg;
    logic signed [31:0] org1_reg [3];
    logic signed [31:0] dir1_reg [3];
    logic signed [31:0] org2_reg [3];
    logic signed [31:0] dir2_reg [3];
    logic signed [63:0] prod2_reg [3];

    always_comb
    begin
        tmin = T_BITS'(t_lo);
        tmax = T_BITS'(t_hi);
        miss = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            miss = miss | lane[i].par_miss;
            if (!lane[i].dir_zero)
            begin
                if (lane[i].t_near > tmin)
                    tmin = lane[i].t_near;
                if (lane[i].t_far < tmax)
                    tmax = lane[i].t_far;
            end
        end
        if (tmax <= tmin)
            miss = 1'b1;
        if (!(tmin > T_BITS'(t_lo) && tmin < T_BITS'(t_hi)))
            miss = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg  <= !miss;
            tmin1_reg <= tmin[31:0];
            hit2_reg  <= hit1_reg;
            tmin2_reg <= tmin1_reg;
            for (int i = 0; i < 3; i++)
            begin
                org1_reg[i]  <= lane[i].org;
                dir1_reg[i]  <= lane[i].dir;
                org2_reg[i]  <= org1_reg[i];
                dir2_reg[i]  <= dir1_reg[i];
                prod2_reg[i] <= dir1_reg[i] * tmin1_reg;
            end
        end
    end

    always_comb
    begin
        logic signed [64:0] pt [3];
        logic signed [31:0] pt_sat [3];
        logic signed [1:0]  nrm [3];
        logic signed [65:0] d_lo, d_hi;
        logic [65:0]        a_lo, a_hi;
        logic signed [33:0] dot;
        logic               front;
        dot = '0;
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = 65'(org2_reg[i]) + 65'(prod2_reg[i] >>> FRAC_BITS);
            d_lo  = 66'(pt[i]) - 66'(box_lo(ctr[i], size[i]));
            d_hi  = 66'(pt[i]) - 66'(box_hi(ctr[i], size[i]));
            a_lo  = d_lo[65] ? 66'(-d_lo) : d_lo;
            a_hi  = d_hi[65] ? 66'(-d_hi) : d_hi;
            if (a_lo < 66'(tol))
                nrm[i] = -2'sd1;
            else if (a_hi < 66'(tol))
                nrm[i] = 2'sd1;
            else
                nrm[i] = 2'sd0;
            case (nrm[i])
                -2'sd1:  dot = dot - 34'(dir2_reg[i]);
                2'sd1:   dot = dot + 34'(dir2_reg[i]);
                default: dot = dot;
            endcase
            if (pt[i] > 65'sh7FFFFFFF)
                pt_sat[i] = 32'sh7FFFFFFF;
            else if (pt[i] < -65'sh80000000)
                pt_sat[i] = 32'sh80000000;
            else
                pt_sat[i] = pt[i][31:0];
        end
        front = dot[33];
        out_data = '0;
        if (hit2_reg)
        begin
            out_data.hit        = 1'b1;
            out_data.t_hit      = tmin2_reg;
            out_data.point_x    = pt_sat[0];
            out_data.point_y    = pt_sat[1];
            out_data.point_z    = pt_sat[2];
            out_data.normal_x   = front ? nrm[0] : -nrm[0];
            out_data.normal_y   = front ? nrm[1] : -nrm[1];
            out_data.normal_z   = front ? nrm[2] : -nrm[2];
            out_data.front_face = front;
        end
    end

    assign out_valid = v2_reg;

endmodule

FILE: sv/rbs_chk.sv
// Port-level checks on the result stream, bound to the top level.
module rbs_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[135:1] == '0)
        else $error("miss carries nonzero fields");

    a_front_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[135] |-> m_tdata[0] && m_tdata[134:129] != 6'd0)
        else $error("front face without hit or normal");

    a_nrm_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[130:129] != 2'b10 && m_tdata[132:131] != 2'b10
                     && m_tdata[134:133] != 2'b10)
        else $error("normal component out of range");
endmodule

bind ray_box_slab_intersect rbs_chk u_rbs_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
